>>> rtl/core/temporal_frame_reducer_core_assert.svh
// ----------------------------------------------------------------------------
// temporal frame reducer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_FRAME_REDUCER_CORE_ASSERT_SVH
`define TEMPORAL_FRAME_REDUCER_CORE_ASSERT_SVH

// condition must never hold
`define TFR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// same-cycle implication
`define TFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg
// Codes and shared types of the temporal frame reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

  // combining operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_MIN = 2'd2;
  localparam logic [1:0] OP_MAX = 2'd3;

  // read status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFRAME = 2'd1;
  localparam logic [1:0] ST_PARTIAL = 2'd2;

  // configuration register indexes
  localparam logic REG_OP_SELECT   = 1'b0;
  localparam logic REG_FRAME_ELEMS = 1'b1;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int FE_W     = 13;
  localparam int RIDX_W   = 12;

  // output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [1:0]                 status;
  } tfr_res_t;

endpackage

`default_nettype wire

>>> rtl/core/tfr_mem.sv
// ----------------------------------------------------------------------------
// tfr_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic [31:0]            rdata
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/tfr_combine.sv
// ----------------------------------------------------------------------------
// tfr_combine
// Two-stage combining unit: raw sum and product, then saturation and select.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_combine
  import tfr_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic [1:0]                  op,
  input  wire logic                        load,
  input  wire logic signed [SAMPLE_W-1:0]  a,
  input  wire logic signed [SAMPLE_W-1:0]  b,
  output logic signed [SAMPLE_W-1:0]       res,
  output logic signed [SAMPLE_W-1:0]       stored
);

  logic signed [SAMPLE_W:0]     sum_q;
  logic signed [2*SAMPLE_W-1:0] prod_q;
  logic signed [SAMPLE_W-1:0]   a_q;
  logic signed [SAMPLE_W-1:0]   b_q;
  logic                         load_q;
  logic signed [2*SAMPLE_W-1:0] prod_sh;
  logic signed [SAMPLE_W-1:0]   sum_sat;
  logic signed [SAMPLE_W-1:0]   mul_sat;
  logic signed [SAMPLE_W-1:0]   max_pos;
  logic signed [SAMPLE_W-1:0]   max_neg;

  assign max_pos = {1'b0, {(SAMPLE_W-1){1'b1}}};
  assign max_neg = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // first stage: exact sum and product
  always_ff @(posedge clk) begin
    sum_q  <= {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    prod_q <= a * b;
    a_q    <= a;
    b_q    <= b;
    load_q <= load;
  end

  // floor shift of the product
  assign prod_sh = prod_q >>> 16;

  // saturation
  always_comb begin
    if (sum_q[SAMPLE_W] != sum_q[SAMPLE_W-1]) begin
      sum_sat = sum_q[SAMPLE_W] ? max_neg : max_pos;
    end else begin
      sum_sat = sum_q[SAMPLE_W-1:0];
    end
    if (prod_sh[2*SAMPLE_W-1:SAMPLE_W-1] != {(SAMPLE_W+1){prod_sh[2*SAMPLE_W-1]}}) begin
      mul_sat = prod_sh[2*SAMPLE_W-1] ? max_neg : max_pos;
    end else begin
      mul_sat = prod_sh[SAMPLE_W-1:0];
    end
  end

  // operation select, first frame passes the sample
  always_comb begin
    if (load_q) begin
      res = b_q;
    end else begin
      case (op)
        OP_ADD:  res = sum_sat;
        OP_MUL:  res = mul_sat;
        OP_MIN:  res = (a_q < b_q) ? a_q : b_q;
        OP_MAX:  res = (a_q > b_q) ? a_q : b_q;
        default: res = sum_sat;
      endcase
    end
  end

  assign stored = a_q;

endmodule

`default_nettype wire

>>> rtl/core/tfr_outq.sv
// ----------------------------------------------------------------------------
// tfr_outq
// Small result queue that decouples the pipeline from the output stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_frame_reducer_core_assert.svh"

module tfr_outq
  import tfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tfr_res_t              din,
  input  wire logic                  pop,
  output tfr_res_t                   dout,
  output logic                       nonempty,
  output logic [OUTQ_CNT_W-1:0]      count
);

  tfr_res_t                entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wptr;
  logic [OUTQ_PTR_W-1:0]   rptr;
  logic [OUTQ_CNT_W-1:0]   count_next;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + OUTQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - OUTQ_CNT_W'(1);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + OUTQ_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assign dout     = entries[rptr];
  assign nonempty = (count != '0);

  `TFR_ASSERT_NEVER(a_outq_overflow, push && !pop && (count == OUTQ_CNT_W'(OUTQ_DEPTH)), "result queue overflow")
  `TFR_ASSERT_NEXT(a_outq_push_seen, push && !pop, count != '0, "pushed item missing from queue")

endmodule

`default_nettype wire

>>> rtl/core/temporal_frame_reducer_core.sv
// Reads pass stages s1 and s2, then the result queue that feeds the output.
// Throughput: one item per cycle while in_stall is low, push or read, set by the
//   single write and read port of the frame store and the two-stage combining unit.
// Input stall rises when the 4-entry result queue and reads in flight are full.
// Reset (rst, synchronous): position 0, first frame loading, op add,
//   frame length 4096; frame store contents are not cleared.
// ----------------------------------------------------------------------------
// temporal_frame_reducer_core
// Element-wise reduction of a sample stream over time in a frame store, with
// read-back of stored elements.
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_frame_reducer_core_assert.svh"

module temporal_frame_reducer_core
  import tfr_pkg::*;
#(
  parameter int MAX_ELEMS = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [FE_W-1:0]            cfg_data,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       func,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [RIDX_W-1:0]          read_index,
  // output channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      value,
  output logic [1:0]                      status
);

  localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int LEN_W  = $clog2(MAX_ELEMS + 1);
  localparam int CMP_W  = (LEN_W > FE_W) ? LEN_W : FE_W;

  typedef struct packed {
    logic              is_read;
    logic              load;
    logic              zero;
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } stage_ctl_t;

  // configuration and frame position
  logic [1:0]              op;
  logic [FE_W-1:0]         frame_elems;
  logic [ADDR_W-1:0]       position;
  logic [ADDR_W-1:0]       position_next;
  logic                    first_pass;
  logic                    first_pass_next;
  logic [CMP_W-1:0]        frame_len;
  logic [CMP_W-1:0]        pos_inc;
  logic                    pos_wrap;
  logic                    accept;

  // pipeline
  stage_ctl_t              s0_ctl;
  logic                    s1_valid;
  stage_ctl_t              s1_ctl;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                    s2_valid;
  stage_ctl_t              s2_ctl;
  logic [31:0]             mem_rdata;
  logic signed [SAMPLE_W-1:0] operand;
  logic signed [SAMPLE_W-1:0] wb_data;
  logic signed [SAMPLE_W-1:0] s2_stored;
  logic                    wb_en;
  logic                    wbq_valid;
  logic [ADDR_W-1:0]       wbq_addr;
  logic signed [SAMPLE_W-1:0] wbq_data;

  // result queue
  tfr_res_t                res_in;
  tfr_res_t                res_out;
  logic                    res_push;
  logic                    res_pop;
  logic [OUTQ_CNT_W-1:0]   q_count;
  logic [OUTQ_CNT_W+1:0]   reserved;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op          <= OP_ADD;
      frame_elems <= FE_W'(4096);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OP_SELECT:   op          <= cfg_data[1:0];
        REG_FRAME_ELEMS: frame_elems <= cfg_data;
        default:         op          <= op;
      endcase
    end
  end

  // effective frame length, clamped to 1..MAX_ELEMS
  always_comb begin
    if (frame_elems == '0) begin
      frame_len = CMP_W'(1);
    end else if (CMP_W'(frame_elems) > CMP_W'(MAX_ELEMS)) begin
      frame_len = CMP_W'(MAX_ELEMS);
    end else begin
      frame_len = CMP_W'(frame_elems);
    end
  end

  assign accept   = in_valid && !in_stall;
  assign pos_inc  = CMP_W'(position) + CMP_W'(1);
  assign pos_wrap = (pos_inc >= frame_len);

  // position counter and first-frame flag
  always_comb begin
    position_next   = position;
    first_pass_next = first_pass;
    if (accept && !func) begin
      if (pos_wrap) begin
        position_next   = '0;
        first_pass_next = 1'b0;
      end else begin
        position_next = pos_inc[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      first_pass <= 1'b1;
    end else begin
      position   <= position_next;
      first_pass <= first_pass_next;
    end
  end

  // issue stage: address and read status
  always_comb begin
    s0_ctl.is_read = func;
    s0_ctl.load    = first_pass;
    s0_ctl.zero    = first_pass || (CMP_W'(read_index) >= frame_len);
    if (first_pass) begin
      s0_ctl.status = ST_NOFRAME;
    end else if (position != '0) begin
      s0_ctl.status = ST_PARTIAL;
    end else begin
      s0_ctl.status = ST_OK;
    end
    s0_ctl.addr = func ? ADDR_W'(read_index) : position;
  end

  tfr_mem #(
    .DEPTH  (MAX_ELEMS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (wb_en),
    .waddr (s2_ctl.addr),
    .wdata (wb_data),
    .raddr (s0_ctl.addr),
    .rdata (mem_rdata)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      wbq_valid <= 1'b0;
    end else begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      wbq_valid <= wb_en;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    s1_ctl    <= s0_ctl;
    s1_sample <= sample;
    s2_ctl    <= s1_ctl;
    wbq_addr  <= s2_ctl.addr;
    wbq_data  <= wb_data;
  end

  // forwarding of writes the store read has not yet seen
  always_comb begin
    if (wb_en && (s2_ctl.addr == s1_ctl.addr)) begin
      operand = wb_data;
    end else if (wbq_valid && (wbq_addr == s1_ctl.addr)) begin
      operand = wbq_data;
    end else begin
      operand = mem_rdata;
    end
  end

  tfr_combine u_combine (
    .clk    (clk),
    .op     (op),
    .load   (s1_ctl.load),
    .a      (operand),
    .b      (s1_sample),
    .res    (wb_data),
    .stored (s2_stored)
  );

  assign wb_en = s2_valid && !s2_ctl.is_read;

  // read results into the queue
  assign res_push      = s2_valid && s2_ctl.is_read;
  assign res_in.value  = s2_ctl.zero ? '0 : s2_stored;
  assign res_in.status = s2_ctl.status;
  assign res_pop       = out_valid && !out_stall;

  tfr_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .din      (res_in),
    .pop      (res_pop),
    .dout     (res_out),
    .nonempty (out_valid),
    .count    (q_count)
  );

  // stall while queued and in-flight reads could fill the queue
  assign reserved = (OUTQ_CNT_W+2)'(q_count)
                  + (OUTQ_CNT_W+2)'(s1_valid && s1_ctl.is_read)
                  + (OUTQ_CNT_W+2)'(s2_valid && s2_ctl.is_read);
  assign in_stall = (reserved >= (OUTQ_CNT_W+2)'(OUTQ_DEPTH));

  assign value  = res_out.value;
  assign status = res_out.status;

  `TFR_ASSERT_NEXT(a_wrap_ends_load, accept && !func && pos_wrap, !first_pass && (position == '0), "frame wrap did not end loading")
  `TFR_ASSERT_IMPL(a_load_only_first, wb_en && s2_ctl.load, $past(first_pass, 2), "load write outside first frame")
  `TFR_ASSERT_NEVER(a_pos_range, CMP_W'(position) >= CMP_W'(MAX_ELEMS), "position beyond store depth")

endmodule

`default_nettype wire

>>> verif/temporal_frame_reducer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// temporal_frame_reducer_core_test
// Self-checking bench for the frame reducer core. The first frame loads the
// low part of the store at a short base length; later lengths stay within it
// but for one oversized setting, so every element that is read or combined
// has been written. A short directed run then covers sample extremes, every
// combining op, odd frame lengths and reads in each status. Random phases
// follow with new op and length settings, random idling on both channels and
// one long output hold-off. A scoreboard predicts every read and checks each
// returned field in order.
// ----------------------------------------------------------------------------

module temporal_frame_reducer_core_test;
  import tfr_pkg::*;

  localparam int STORE_DEPTH   = 4096;
  localparam int BASE_LEN      = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int NUM_PHASES    = 14;
  localparam int PHASE_ITEMS   = 38;
  localparam int HOLD_PHASE    = 5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // frame length per random phase, mostly short, never above the base length
  localparam int PHASE_LEN [NUM_PHASES] =
    '{1, 3, 256, 7, 0, 16, 255, 2, 5, 64, 200, 12, 4, 9};

  // tracks the stored frame and the reads still owed by the block
  class frame_reducer_scoreboard;
    logic signed [SAMPLE_W-1:0] frame_copy [STORE_DEPTH];
    int unsigned                cursor = 0;
    bit                         first_frame = 1'b1;
    logic [1:0]                 op_code = OP_ADD;
    logic [FE_W-1:0]            elems_reg = 13'd4096;
    tfr_res_t                   awaited [$];
    int                         fail_count = 0;
    int                         push_count = 0;
    int                         read_count = 0;
    int                         status_count [3] = '{0, 0, 0};

    function int unsigned frame_len();
      if (elems_reg == 0) return 1;
      if (elems_reg > STORE_DEPTH) return STORE_DEPTH;
      return 32'(elems_reg);
    endfunction

    function void set_reg(logic idx, logic [FE_W-1:0] data);
      if (idx == REG_OP_SELECT) op_code = data[1:0];
      else elems_reg = data;
    endfunction

    function logic signed [SAMPLE_W-1:0] clamp(logic signed [63:0] x);
      if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return 32'sh8000_0000;
      return x[SAMPLE_W-1:0];
    endfunction

    function logic signed [SAMPLE_W-1:0] combine_elem(logic signed [SAMPLE_W-1:0] held,
                                                      logic signed [SAMPLE_W-1:0] incoming);
      logic signed [63:0] wide;
      case (op_code)
        OP_ADD: begin
          wide = 64'(held);
          wide = wide + 64'(incoming);
          return clamp(wide);
        end
        OP_MUL: begin
          wide = 64'(held);
          wide = wide * 64'(incoming);
          return clamp(wide >>> 16);
        end
        OP_MIN: return (held < incoming) ? held : incoming;
        default: return (held > incoming) ? held : incoming;
      endcase
    endfunction

    function void note_item(logic f, logic signed [SAMPLE_W-1:0] s, logic [RIDX_W-1:0] idx);
      tfr_res_t res;
      if (f == FUNC_PUSH) begin
        frame_copy[cursor] = first_frame ? s : combine_elem(frame_copy[cursor], s);
        cursor++;
        if (cursor >= frame_len()) begin
          cursor = 0;
          first_frame = 1'b0;
        end
        push_count++;
      end else begin
        if (first_frame) res.status = ST_NOFRAME;
        else if (cursor != 0) res.status = ST_PARTIAL;
        else res.status = ST_OK;
        res.value = (!first_frame && idx < frame_len()) ? frame_copy[idx] : '0;
        awaited.push_back(res);
        read_count++;
        status_count[res.status]++;
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] v, logic [1:0] st);
      tfr_res_t want;
      if (awaited.size() == 0) begin
        $error("result with no read waiting: value %h status %0d", v, st);
        fail_count++;
        return;
      end
      want = awaited.pop_front();
      if (v !== want.value) begin
        $error("value: expected %h, actual %h", want.value, v);
        fail_count++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        fail_count++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [FE_W-1:0]            cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       func;
  logic signed [SAMPLE_W-1:0] sample;
  logic [RIDX_W-1:0]          read_index;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] value;
  logic [1:0]                 status;

  frame_reducer_scoreboard board = new();

  int tx_idle_rate = 0;
  int rx_idle_rate = 0;
  bit hold_req     = 1'b0;
  bit took;
  int quiet_cycles = 0;
  int held_cycles  = 0;
  int reg_writes   = 0;

  temporal_frame_reducer_core #(
    .MAX_ELEMS(STORE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .sample    (sample),
    .read_index(read_index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // accepted items on both channels, plus the no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      took = 1'b0;
      if (out_valid && !out_stall) begin
        board.check_result(value, status);
        took = 1'b1;
      end
      if (in_valid && !in_stall) begin
        board.note_item(func, sample, read_index);
        took = 1'b1;
      end
      if (in_valid && in_stall) held_cycles++;
      if (took) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // output side: long hold-off on request, otherwise random stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_rate != 0 && $urandom_range(0, rx_idle_rate - 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          3: return -32'sh1;
          default: return 32'sh0001_0000;
        endcase
      end
      // around +-4.0 so products stay in range
      3, 4: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      default: return 32'($urandom_range(0, 32'h200_0000)) - 32'h100_0000;
    endcase
  endfunction

  function automatic logic [RIDX_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return RIDX_W'($urandom_range(0, STORE_DEPTH - 1));
      default: return RIDX_W'($urandom_range(0, board.frame_len() - 1));
    endcase
  endfunction

  // offer one item and hold it until taken; valid stays high on return
  task automatic send_item(input logic f, input logic signed [SAMPLE_W-1:0] s,
                           input logic [RIDX_W-1:0] idx);
    if (tx_idle_rate != 0 && $urandom_range(0, tx_idle_rate - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    sample     <= s;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_push(input logic signed [SAMPLE_W-1:0] s);
    send_item(FUNC_PUSH, s, RIDX_W'($urandom()));
  endtask

  task automatic send_read(input logic [RIDX_W-1:0] idx);
    send_item(FUNC_READ, $urandom(), idx);
  endtask

  // stop offering, wait for every read to return, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [FE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
    reg_writes++;
    @(negedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_OP_SELECT;
    cfg_data   = '0;
    in_valid   = 1'b0;
    func       = FUNC_PUSH;
    sample     = '0;
    read_index = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // base frame length, the upper bound of every later length but one oversized setting
    write_reg(REG_FRAME_ELEMS, FE_W'(BASE_LEN));

    // reads before and during the first frame, sample extremes
    send_read('0);
    send_read('1);
    send_push(32'sh7FFF_FFFF);
    send_push(32'sh8000_0000);
    send_push(32'sh0);
    send_push(-32'sh1);
    send_read(RIDX_W'(1));

    // rest of the first frame at the base length
    tx_idle_rate = 6;
    rx_idle_rate = 6;
    for (int i = 4; i < BASE_LEN; i++) begin
      if ($urandom_range(0, 63) == 0) send_read(RIDX_W'($urandom()));
      send_push(rand_sample());
    end
    send_read('0);
    send_read('1);
    drain();

    // zero length acts as a one-element frame: every push hits element 0
    tx_idle_rate = 0;
    rx_idle_rate = 0;
    write_reg(REG_FRAME_ELEMS, '0);
    write_reg(REG_OP_SELECT, FE_W'(OP_ADD));
    send_push(32'sh7FFF_FFFF);
    send_read('0);
    drain();
    write_reg(REG_OP_SELECT, FE_W'(OP_MUL));
    send_push(32'sh8000_0000);
    send_read('0);
    send_push(32'sh8000_0000);
    send_read('0);
    drain();
    write_reg(REG_OP_SELECT, FE_W'(OP_MIN));
    send_push(-32'sh1);
    send_read('0);
    drain();
    write_reg(REG_OP_SELECT, FE_W'(OP_MAX));
    send_push(32'sh8000_0000);
    send_read('0);
    drain();

    // oversized length clamps to the store; partial frame, then shrink mid-frame
    write_reg(REG_FRAME_ELEMS, '1);
    send_read(RIDX_W'(BASE_LEN - 1));
    repeat (3) send_push(rand_sample());
    send_read(RIDX_W'(2));
    drain();
    write_reg(REG_FRAME_ELEMS, FE_W'(2));
    send_push(rand_sample());
    send_read(RIDX_W'(3));
    send_read(RIDX_W'(1));
    drain();

    // random phases, each with its own op and frame length
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_OP_SELECT, (p < 8) ? FE_W'(p % 4) : FE_W'($urandom_range(0, 3)));
      write_reg(REG_FRAME_ELEMS, FE_W'(PHASE_LEN[p]));
      if (p >= NUM_PHASES - 2) begin
        tx_idle_rate = 0;
        rx_idle_rate = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: tx_idle_rate = 0;
          1: tx_idle_rate = 3;
          default: tx_idle_rate = 8;
        endcase
        case ($urandom_range(0, 2))
          0: rx_idle_rate = 0;
          1: rx_idle_rate = 3;
          default: rx_idle_rate = 8;
        endcase
      end
      // send reads into a held-off output so that the input backs up
      if (p == HOLD_PHASE) begin
        tx_idle_rate = 0;
        hold_req = 1'b1;
        repeat (40) send_read(pick_index());
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) send_read(pick_index());
        else send_push(rand_sample());
      end
      drain();
    end

    $display("covered %0d pushes and %0d reads over %0d register writes, all four ops,",
             board.push_count, board.read_count, reg_writes);
    $display("frame lengths 0 to %0d and oversized; reads ok/no-frame/partial %0d/%0d/%0d,",
             BASE_LEN, board.status_count[ST_OK], board.status_count[ST_NOFRAME],
             board.status_count[ST_PARTIAL]);
    $display("input held %0d cycles", held_cycles);
    if (board.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
